### rtl/core/adjacency_matrix_graph_store_top_macros.svh
// Assertion macros used by the port-level checker of the graph store.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_TOP_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("graph store check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AMGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("graph store check failed");

`endif

### rtl/core/amgs_pkg.sv
// Shared types and constants of the adjacency matrix graph store.
package amgs_pkg;

	localparam int ACTION_W         = 3;
	localparam int ID_W             = 6;
	localparam int ID_SPACE         = 64;
	localparam int TOTAL_W          = 7;
	localparam int TALLY_W          = 16;
	localparam int VERTEX_SLOTS_DEF = 64;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	typedef logic [ACTION_W-1:0] action_t;

	localparam action_t ACT_ADD_VERTEX  = 3'd0;
	localparam action_t ACT_ADD_EDGE    = 3'd1;
	localparam action_t ACT_TEST_EDGE   = 3'd2;
	localparam action_t ACT_TEST_VERTEX = 3'd3;
	localparam action_t ACT_COUNT       = 3'd4;
	localparam action_t ACT_LIST        = 3'd5;

endpackage

### rtl/core/amgs_ram.sv
// Generic simple dual-port RAM with a registered read port.
module amgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/adjacency_matrix_graph_store_top.sv
// Directed graph store: vertex list and adjacency bit matrix with a request sequencer.
//
// The block takes one request at a time: it is accepted at a rising edge with start
// high and busy low, and busy stays high until the request's final result has been
// produced. Results come out on done for exactly one cycle each and cannot be held
// off, so a receiver must take every result in the cycle it appears. A request is
// served by scanning the vertex list memory one entry per cycle through its single
// read port; add vertex, add edge, test vertex and count neighbours scan it once,
// test edge and unused action codes do not scan it, and a neighbour listing first
// counts the neighbours and then scans the list again to deliver them in list order,
// one result per neighbour, with the last one marked. No result appears in a listing
// until the count is known. The adjacency matrix lives in a 64 x 64 bit memory
// indexed by vertex id, one row per origin; each row has a valid bit in flip-flops,
// cleared by reset, so the matrix reads as all zero after reset without any clearing
// pass and the block is ready in the first cycle after reset. Writes to both memories
// happen in the final cycle of a request while busy is still high, so the next
// request always reads the updated state. The vertex list holds up to VERTEX_SLOTS
// ids; an add of a new id beyond that reports an error.
module adjacency_matrix_graph_store_top #(
	parameter int VERTEX_SLOTS = amgs_pkg::VERTEX_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [amgs_pkg::ACTION_W-1:0] action,
	input  logic [amgs_pkg::ID_W-1:0]     from_id,
	input  logic [amgs_pkg::ID_W-1:0]     to_id,
	output logic                         done,
	output logic                         status,
	output logic                         found,
	output logic [amgs_pkg::TOTAL_W-1:0] neighbour_count,
	output logic [amgs_pkg::ID_W-1:0]     neighbour_id,
	output logic                         last,
	output logic [amgs_pkg::TOTAL_W-1:0] vertex_total,
	output logic [amgs_pkg::TALLY_W-1:0] edge_total
);

	localparam int IDX_W = $clog2(VERTEX_SLOTS);
	localparam logic [amgs_pkg::TOTAL_W-1:0] SLOTS_C = amgs_pkg::TOTAL_W'(VERTEX_SLOTS);
	localparam logic [amgs_pkg::TOTAL_W-1:0] ONE_C   = amgs_pkg::TOTAL_W'(1);

	// The sequencer is idle, running the first pass over the vertex list, or running
	// the second pass of a listing that delivers the neighbours.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_LIST = 3'b100
	} state_t;

	typedef logic [amgs_pkg::ID_SPACE-1:0] row_t;

	state_t                        state_q;
	amgs_pkg::action_t             action_q;
	logic [amgs_pkg::ID_W-1:0]     a_q;
	logic [amgs_pkg::ID_W-1:0]     b_q;
	logic [amgs_pkg::TOTAL_W-1:0]  used_q;
	logic [amgs_pkg::TALLY_W-1:0]  tally_q;
	logic [amgs_pkg::TOTAL_W-1:0]  issue_q;
	logic [amgs_pkg::TOTAL_W-1:0]  lim_q;
	logic                          pend_s1;
	logic                          row_vld_q;
	logic                          pres_a_q;
	logic                          pres_b_q;
	logic [amgs_pkg::TOTAL_W-1:0]  cnt_q;
	logic [amgs_pkg::TOTAL_W-1:0]  k_q;
	row_t                          row_valid_q;

	logic                          done_q;
	logic                          status_q;
	logic                          found_q;
	logic [amgs_pkg::TOTAL_W-1:0]  count_q;
	logic [amgs_pkg::ID_W-1:0]     nid_q;
	logic                          last_q;
	logic [amgs_pkg::TOTAL_W-1:0]  vtotal_q;
	logic [amgs_pkg::TALLY_W-1:0]  etotal_q;

	// Memory ports.
	logic                          vl_we;
	logic                          vl_re;
	logic [amgs_pkg::ID_W-1:0]     vl_rdata;
	logic                          adj_we;
	logic                          adj_re;
	row_t                          adj_rdata;
	row_t                          adj_wdata;

	// Scan and finish logic.
	logic                          accept;
	logic                          needs_scan;
	row_t                          row_eff;
	logic                          hit_a;
	logic                          hit_b;
	logic                          edge_hit;
	logic                          scan_issue;
	logic                          scan_end;
	logic                          finish;
	logic                          go_list;
	logic                          fin_status;
	logic                          fin_found;
	logic [amgs_pkg::TOTAL_W-1:0]  fin_cnt;
	logic [amgs_pkg::TOTAL_W-1:0]  used_nxt;
	logic [amgs_pkg::TALLY_W-1:0]  tally_nxt;
	logic                          list_emit;
	logic                          list_last;
	logic                          emit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		case (action) inside
			amgs_pkg::ACT_ADD_VERTEX, amgs_pkg::ACT_ADD_EDGE, amgs_pkg::ACT_TEST_VERTEX,
			amgs_pkg::ACT_COUNT, amgs_pkg::ACT_LIST: needs_scan = 1'b1;
			default:      needs_scan = 1'b0;
		endcase
	end

	// The row of the origin read at acceptance stays in the RAM output register for
	// the whole request, since the adjacency memory is read only at acceptance.
	assign row_eff    = row_vld_q ? adj_rdata : '0;
	assign hit_a      = (vl_rdata == a_q);
	assign hit_b      = (vl_rdata == b_q);
	assign edge_hit   = row_eff[vl_rdata];
	assign scan_issue = busy && (issue_q < lim_q);
	assign scan_end   = (issue_q >= lim_q) && !pend_s1;
	assign finish     = (state_q == ST_SCAN) && scan_end;

	assign vl_re  = scan_issue;
	assign adj_re = accept;
	assign adj_wdata = row_eff | (row_t'(1) << b_q);

	// Outcome of a request at the end of its first pass.
	always_comb begin
		fin_status = 1'b0;
		fin_found  = 1'b0;
		fin_cnt    = '0;
		go_list    = 1'b0;
		vl_we      = 1'b0;
		adj_we     = 1'b0;
		used_nxt   = used_q;
		tally_nxt  = tally_q;
		case (action_q)
			amgs_pkg::ACT_ADD_VERTEX: begin
				if (pres_a_q) begin
					fin_found = 1'b1;
				end else if (used_q >= SLOTS_C) begin
					fin_status = 1'b1;
				end else begin
					vl_we    = finish;
					used_nxt = used_q + ONE_C;
				end
			end
			amgs_pkg::ACT_ADD_EDGE: begin
				if (!(pres_a_q && pres_b_q)) begin
					fin_status = 1'b1;
				end else begin
					adj_we = finish;
					if (tally_q != amgs_pkg::TALLY_MAX) begin
						tally_nxt = tally_q + amgs_pkg::TALLY_W'(1);
					end
				end
			end
			amgs_pkg::ACT_TEST_EDGE: begin
				fin_found = row_eff[b_q];
			end
			amgs_pkg::ACT_TEST_VERTEX: begin
				fin_found = pres_a_q;
			end
			amgs_pkg::ACT_COUNT: begin
				fin_cnt = cnt_q;
			end
			amgs_pkg::ACT_LIST: begin
				go_list = (cnt_q != '0);
			end
			default: begin
				fin_status = 1'b1;
			end
		endcase
	end

	// In the second pass of a listing every entry with an edge yields one result.
	assign list_emit = (state_q == ST_LIST) && pend_s1 && edge_hit;
	assign list_last = ((k_q + ONE_C) == cnt_q);
	assign emit      = (finish && !go_list) || list_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			action_q    <= '0;
			a_q         <= '0;
			b_q         <= '0;
			used_q      <= '0;
			tally_q     <= '0;
			issue_q     <= '0;
			lim_q       <= '0;
			pend_s1     <= 1'b0;
			row_vld_q   <= 1'b0;
			pres_a_q    <= 1'b0;
			pres_b_q    <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
			row_valid_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= emit;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_SCAN;
						action_q  <= action;
						a_q       <= from_id;
						b_q       <= to_id;
						issue_q   <= '0;
						lim_q     <= needs_scan ? used_q : '0;
						pend_s1   <= 1'b0;
						row_vld_q <= row_valid_q[from_id];
						pres_a_q  <= 1'b0;
						pres_b_q  <= 1'b0;
						cnt_q     <= '0;
					end
				end
				ST_SCAN: begin
					pend_s1 <= scan_issue;
					if (scan_issue) begin
						issue_q <= issue_q + ONE_C;
					end
					if (pend_s1) begin
						pres_a_q <= pres_a_q | hit_a;
						pres_b_q <= pres_b_q | hit_b;
						if (edge_hit) begin
							cnt_q <= cnt_q + ONE_C;
						end
					end
					if (scan_end) begin
						if (go_list) begin
							state_q <= ST_LIST;
							issue_q <= '0;
							k_q     <= '0;
						end else begin
							state_q <= ST_IDLE;
							used_q  <= used_nxt;
							tally_q <= tally_nxt;
							if (adj_we) begin
								row_valid_q[a_q] <= 1'b1;
							end
						end
					end
				end
				ST_LIST: begin
					pend_s1 <= scan_issue;
					if (scan_issue) begin
						issue_q <= issue_q + ONE_C;
					end
					if (list_emit) begin
						k_q <= k_q + ONE_C;
						if (list_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload, loaded only when a result is produced.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (list_emit) begin
				status_q <= 1'b0;
				found_q  <= 1'b1;
				count_q  <= cnt_q;
				nid_q    <= vl_rdata;
				last_q   <= list_last;
				vtotal_q <= used_q;
				etotal_q <= tally_q;
			end else begin
				status_q <= fin_status;
				found_q  <= fin_found;
				count_q  <= fin_cnt;
				nid_q    <= '0;
				last_q   <= 1'b1;
				vtotal_q <= used_nxt;
				etotal_q <= tally_nxt;
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign found           = found_q;
	assign neighbour_count = count_q;
	assign neighbour_id    = nid_q;
	assign last            = last_q;
	assign vertex_total    = vtotal_q;
	assign edge_total      = etotal_q;

	// Vertex ids in insertion order.
	amgs_ram #(
		.WIDTH (amgs_pkg::ID_W),
		.DEPTH (VERTEX_SLOTS)
	) u_vertex_ram (
		.clk   (clk),
		.we    (vl_we),
		.waddr (used_q[IDX_W-1:0]),
		.wdata (a_q),
		.re    (vl_re),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (vl_rdata)
	);

	// Adjacency rows, indexed by origin id.
	amgs_ram #(
		.WIDTH (amgs_pkg::ID_SPACE),
		.DEPTH (amgs_pkg::ID_SPACE)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (a_q),
		.wdata (adj_wdata),
		.re    (adj_re),
		.raddr (from_id),
		.rdata (adj_rdata)
	);

endmodule

### rtl/core/amgs_checker.sv
// Port-level checker for the graph store, bound to its top level.
`include "adjacency_matrix_graph_store_top_macros.svh"

module amgs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         status,
	input logic                         found,
	input logic                         last,
	input logic [amgs_pkg::TOTAL_W-1:0] neighbour_count
);

	// An accepted request always keeps the block busy in the next cycle.
	`AMGS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// While a listing result that is not the last one is shown, the block is busy.
	`AMGS_ASSERT_NOW(a_list_continues, clk, arst_n, done && !last, busy)

	// An error result never reports a hit and always ends its request.
	`AMGS_ASSERT_NOW(a_error_shape, clk, arst_n, done && status, !found && last)

	// A listing result before the last one carries a neighbour and a nonzero count.
	`AMGS_ASSERT_NOW(a_list_shape, clk, arst_n, done && !last, found && (neighbour_count != '0))

endmodule

bind adjacency_matrix_graph_store_top amgs_checker u_amgs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.status          (status),
	.found           (found),
	.last            (last),
	.neighbour_count (neighbour_count)
);

### tb/graph_store_monitor.sv
// Passive monitor for the graph store: mirrors the graph, predicts every result and checks it.
module graph_store_monitor
	import amgs_pkg::*;
#(
	parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  action_t            action,
	input  logic [ID_W-1:0]    from_id,
	input  logic [ID_W-1:0]    to_id,
	input  logic               done,
	input  logic               status,
	input  logic               found,
	input  logic [TOTAL_W-1:0] neighbour_count,
	input  logic [ID_W-1:0]    neighbour_id,
	input  logic               last,
	input  logic [TOTAL_W-1:0] vertex_total,
	input  logic [TALLY_W-1:0] edge_total,
	output int                 fault_total,
	output int                 replies_due
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic               status;
		logic               found;
		logic [TOTAL_W-1:0] neighbours;
		logic [ID_W-1:0]    neighbour;
		logic               last;
		logic [TOTAL_W-1:0] vertices;
		logic [TALLY_W-1:0] edges;
	} reply_t;

	// Mirror of the graph held by the block.
	logic [ID_W-1:0]     stored_ids [ID_SPACE];
	int                  stored_count = 0;
	logic [ID_SPACE-1:0] adj_rows [ID_SPACE];
	logic [TALLY_W-1:0]  edge_count = '0;

	reply_t pending_replies [$];
	int     faults = 0;

	function automatic logic is_stored(logic [ID_W-1:0] id);
		for (int i = 0; i < stored_count; i++)
			if (stored_ids[i] == id)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic int out_degree(logic [ID_W-1:0] id);
		int c;
		c = 0;
		for (int i = 0; i < stored_count; i++)
			if (adj_rows[id][stored_ids[i]])
				c++;
		return c;
	endfunction

	// Totals are taken after the request has updated the graph.
	function automatic void post_reply(logic st, logic fd, logic [TOTAL_W-1:0] cnt,
			logic [ID_W-1:0] nid, logic fin);
		reply_t r;
		r.status     = st;
		r.found      = fd;
		r.neighbours = cnt;
		r.neighbour  = nid;
		r.last       = fin;
		r.vertices   = TOTAL_W'(stored_count);
		r.edges      = edge_count;
		pending_replies.push_back(r);
	endfunction

	task automatic serve_request(action_t act, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
		int total;
		int k;
		case (act)
			ACT_ADD_VERTEX: begin
				if (is_stored(a)) begin
					post_reply(1'b0, 1'b1, '0, '0, 1'b1);
				end else if (stored_count >= VERTEX_SLOTS) begin
					post_reply(1'b1, 1'b0, '0, '0, 1'b1);
				end else begin
					stored_ids[stored_count] = a;
					stored_count++;
					post_reply(1'b0, 1'b0, '0, '0, 1'b1);
				end
			end
			ACT_ADD_EDGE: begin
				if (!is_stored(a) || !is_stored(b)) begin
					post_reply(1'b1, 1'b0, '0, '0, 1'b1);
				end else begin
					adj_rows[a][b] = 1'b1;
					if (edge_count != TALLY_MAX)
						edge_count++;
					post_reply(1'b0, 1'b0, '0, '0, 1'b1);
				end
			end
			ACT_TEST_EDGE:   post_reply(1'b0, adj_rows[a][b], '0, '0, 1'b1);
			ACT_TEST_VERTEX: post_reply(1'b0, is_stored(a), '0, '0, 1'b1);
			ACT_COUNT:       post_reply(1'b0, 1'b0, TOTAL_W'(out_degree(a)), '0, 1'b1);
			ACT_LIST: begin
				total = out_degree(a);
				if (total == 0) begin
					post_reply(1'b0, 1'b0, '0, '0, 1'b1);
				end else begin
					k = 0;
					for (int i = 0; i < stored_count; i++)
						if (adj_rows[a][stored_ids[i]]) begin
							k++;
							post_reply(1'b0, 1'b1, TOTAL_W'(total), stored_ids[i], k == total);
						end
				end
			end
			default: post_reply(1'b1, 1'b0, '0, '0, 1'b1);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t seen;
		reply_t want;
		if (!arst_n) begin
			pending_replies.delete();
			stored_count = 0;
			edge_count = '0;
			for (int i = 0; i < ID_SPACE; i++) begin
				stored_ids[i] = '0;
				adj_rows[i] = '0;
			end
		end else begin
			// Results are retired before a new transaction is predicted, since a final
			// result and the next acceptance can share one edge.
			if (done) begin
				seen.status     = status;
				seen.found      = found;
				seen.neighbours = neighbour_count;
				seen.neighbour  = neighbour_id;
				seen.last       = last;
				seen.vertices   = vertex_total;
				seen.edges      = edge_total;
				if (pending_replies.size() == 0) begin
					faults++;
					if (faults <= REPORT_LIMIT)
						$display("unexpected result: st=%0d fd=%0d cnt=%0d id=%0d last=%0d",
							seen.status, seen.found, seen.neighbours, seen.neighbour, seen.last);
				end else begin
					want = pending_replies.pop_front();
					if (seen !== want) begin
						faults++;
						if (faults <= REPORT_LIMIT) begin
							$display("mismatch: expected st=%0d fd=%0d cnt=%0d id=%0d last=%0d vt=%0d et=%0d",
								want.status, want.found, want.neighbours, want.neighbour,
								want.last, want.vertices, want.edges);
							$display("          got      st=%0d fd=%0d cnt=%0d id=%0d last=%0d vt=%0d et=%0d",
								seen.status, seen.found, seen.neighbours, seen.neighbour,
								seen.last, seen.vertices, seen.edges);
						end
					end
				end
			end
			if (start && !busy)
				serve_request(action, from_id, to_id);
		end
		fault_total <= faults;
		replies_due <= pending_replies.size();
	end

endmodule

### tb/adjacency_matrix_graph_store_top_tb.sv
// Testbench top for the graph store: request stimulus, watchdog and the final verdict.
module adjacency_matrix_graph_store_top_tb;
	import amgs_pkg::*;

	localparam int SLOTS          = VERTEX_SLOTS_DEF;
	// A listing over a full vertex list is quiet through its first pass plus a short sender
	// gap, and the settle wait at the end is longer still. The limit is far above both.
	localparam int STALL_LIMIT    = 2000;
	// Cycles left for stray results once nothing is outstanding any more.
	localparam int SETTLE_CYCLES  = 200;
	localparam int RANDOM_ITEMS   = 150;

	// Action codes the block does not define; both must be answered with an error.
	localparam action_t ACT_SPARE_LO = 3'd6;
	localparam action_t ACT_SPARE_HI = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	action_t            action = ACT_ADD_VERTEX;
	logic [ID_W-1:0]    from_id = '0;
	logic [ID_W-1:0]    to_id = '0;
	logic               busy;
	logic               done;
	logic               status;
	logic               found;
	logic [TOTAL_W-1:0] neighbour_count;
	logic [ID_W-1:0]    neighbour_id;
	logic               last;
	logic [TOTAL_W-1:0] vertex_total;
	logic [TALLY_W-1:0] edge_total;

	int fault_total;
	int replies_due;

	int stall_cycles = 0;
	int issued = 0;
	int quiet_left = 0;
	logic gaps_on = 1'b0;
	// Ids this bench has asked to add. With a full-size list every add of a new id
	// succeeds, so this is also the set of stored vertices; it only steers stimulus.
	logic [ID_SPACE-1:0] requested = '0;

	adjacency_matrix_graph_store_top #(
		.VERTEX_SLOTS(SLOTS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.from_id        (from_id),
		.to_id          (to_id),
		.done           (done),
		.status         (status),
		.found          (found),
		.neighbour_count(neighbour_count),
		.neighbour_id   (neighbour_id),
		.last           (last),
		.vertex_total   (vertex_total),
		.edge_total     (edge_total)
	);

	// The monitor watches both channels and owns all prediction and comparison.
	graph_store_monitor #(
		.VERTEX_SLOTS(SLOTS)
	) u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.from_id        (from_id),
		.to_id          (to_id),
		.done           (done),
		.status         (status),
		.found          (found),
		.neighbour_count(neighbour_count),
		.neighbour_id   (neighbour_id),
		.last           (last),
		.vertex_total   (vertex_total),
		.edge_total     (edge_total),
		.fault_total    (fault_total),
		.replies_due    (replies_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: any cycle without a transaction on either side counts toward the limit.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Random sender idling: gaps in which start is low, broken up by stretches
	// in which requests follow each other back to back.
	task automatic take_gap();
		if (quiet_left > 0) begin
			quiet_left--;
		end else if ($urandom_range(9) == 0) begin
			quiet_left = $urandom_range(20, 8);
		end else if ($urandom_range(2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	// Present one request and hold it until the transaction is accepted. Signals are
	// read right after the edge, so busy here is the value the block had at that edge.
	// start stays high on return, so a following request keeps the port busy.
	task automatic issue(action_t act, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
		if (gaps_on)
			take_gap();
		start   <= 1'b1;
		action  <= act;
		from_id <= a;
		to_id   <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		issued++;
		if (act == ACT_ADD_VERTEX)
			requested[a] = 1'b1;
	endtask

	// Hold the sender off until every predicted result has come back. The monitor's
	// count is registered, so the loop waits on the clock before it reads the count.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (replies_due != 0);
	endtask

	function automatic logic [ID_W-1:0] any_id();
		return ID_W'($urandom_range(ID_SPACE - 1));
	endfunction

	function automatic logic [ID_W-1:0] known_id();
		logic [ID_W-1:0] id;
		do
			id = any_id();
		while (!requested[id]);
		return id;
	endfunction

	// Mostly stored ids, so that edge requests get past the membership checks.
	function automatic logic [ID_W-1:0] some_id();
		if ($urandom_range(4) == 0)
			return any_id();
		return known_id();
	endfunction

	function automatic logic [ID_W-1:0] fresh_id();
		logic [ID_W-1:0] id;
		if (&requested)
			return any_id();
		do
			id = any_id();
		while (requested[id]);
		return id;
	endfunction

	initial begin
		int kind;
		int span;
		int mark;
		int offset;
		int stride;
		logic [ID_W-1:0] hub;
		logic [ID_W-1:0] id;

		// Reset is applied once, at the start, and never again.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		gaps_on = 1'b1;

		// Directed part: empty graph queries, the id extremes, duplicates, missing
		// edge ends, a repeated edge, a self loop and both undefined action codes.
		issue(ACT_TEST_VERTEX, 6'd0, 6'd63);
		issue(ACT_LIST, 6'd0, 6'd0);
		issue(ACT_COUNT, 6'd63, 6'd0);
		issue(ACT_ADD_EDGE, 6'd0, 6'd63);
		issue(ACT_ADD_VERTEX, 6'd0, 6'd0);
		issue(ACT_ADD_VERTEX, 6'd63, 6'd63);
		issue(ACT_ADD_VERTEX, 6'd0, 6'd21);
		issue(ACT_ADD_VERTEX, 6'd21, 6'd0);
		issue(ACT_ADD_VERTEX, 6'd42, 6'd0);
		issue(ACT_ADD_EDGE, 6'd0, 6'd63);
		issue(ACT_ADD_EDGE, 6'd0, 6'd63);
		issue(ACT_ADD_EDGE, 6'd0, 6'd5);
		issue(ACT_ADD_EDGE, 6'd5, 6'd0);
		issue(ACT_ADD_EDGE, 6'd63, 6'd0);
		issue(ACT_ADD_EDGE, 6'd0, 6'd21);
		issue(ACT_ADD_EDGE, 6'd0, 6'd42);
		issue(ACT_ADD_EDGE, 6'd0, 6'd0);
		issue(ACT_TEST_EDGE, 6'd0, 6'd63);
		issue(ACT_TEST_EDGE, 6'd63, 6'd63);
		issue(ACT_TEST_EDGE, 6'd5, 6'd7);
		issue(ACT_TEST_VERTEX, 6'd63, 6'd0);
		issue(ACT_TEST_VERTEX, 6'd5, 6'd0);
		issue(ACT_COUNT, 6'd0, 6'd0);
		issue(ACT_LIST, 6'd0, 6'd0);
		issue(ACT_SPARE_LO, 6'd42, 6'd21);
		issue(ACT_SPARE_HI, 6'd63, 6'd63);

		// Let everything come back before the random part.
		drain();

		// Random part: short well-formed sequences with random content, plus noise.
		mark = issued;
		while (issued - mark < RANDOM_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				issue(ACT_ADD_VERTEX, ($urandom_range(3) == 0) ? any_id() : fresh_id(), any_id());
			end else if (kind < 45) begin
				hub = some_id();
				issue(ACT_ADD_EDGE, hub, some_id());
				if ($urandom_range(1) == 0)
					issue(($urandom_range(1) == 0) ? ACT_COUNT : ACT_LIST, hub, any_id());
			end else if (kind < 60) begin
				// Fan out from one vertex, then list it back.
				hub = known_id();
				span = $urandom_range(6, 1);
				repeat (span)
					issue(ACT_ADD_EDGE, hub, known_id());
				issue(ACT_LIST, hub, any_id());
			end else if (kind < 75) begin
				if ($urandom_range(1) == 0)
					issue(ACT_TEST_EDGE, some_id(), some_id());
				else
					issue(ACT_TEST_VERTEX, some_id(), any_id());
			end else if (kind < 85) begin
				issue(($urandom_range(1) == 0) ? ACT_COUNT : ACT_LIST, some_id(), any_id());
			end else begin
				issue(action_t'($urandom_range(7)), any_id(), any_id());
			end
			if ($urandom_range(49) == 0)
				drain();
		end

		// Last part, without idling: fill the list, connect one vertex to every
		// vertex and list it, which gives the longest listing the block can make.
		gaps_on = 1'b0;
		offset = $urandom_range(ID_SPACE - 1);
		stride = 2 * $urandom_range(31) + 1;
		for (int i = 0; i < ID_SPACE; i++) begin
			id = ID_W'(offset + i * stride);
			if (!requested[id])
				issue(ACT_ADD_VERTEX, id, any_id());
		end
		hub = any_id();
		offset = $urandom_range(ID_SPACE - 1);
		stride = 2 * $urandom_range(31) + 1;
		for (int i = 0; i < ID_SPACE; i++)
			issue(ACT_ADD_EDGE, hub, ID_W'(offset + i * stride));
		issue(ACT_COUNT, hub, any_id());
		issue(ACT_LIST, hub, any_id());
		issue(ACT_ADD_VERTEX, any_id(), any_id());
		repeat (10)
			issue(action_t'($urandom_range(ACT_LIST)), any_id(), any_id());

		// Wait for the outstanding results, then leave room for anything stray.
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fault_total == 0 && replies_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/amgs_pkg.sv
rtl/core/amgs_ram.sv
rtl/core/adjacency_matrix_graph_store_top.sv
rtl/core/amgs_checker.sv
tb/graph_store_monitor.sv
tb/adjacency_matrix_graph_store_top_tb.sv
